// ----- rtl/core/tcw_pkg.sv -----
// Package for the text console writer: screen geometry, cell codes,
// command codes, controller states and the controller/datapath structs.
// No dependencies.
package tcw_pkg;

  localparam int SCREEN_COLS = 80;
  localparam int SCREEN_ROWS = 25;
  localparam int CELL_COUNT  = SCREEN_COLS * SCREEN_ROWS;
  localparam int COPY_COUNT  = SCREEN_COLS * (SCREEN_ROWS - 1);
  localparam int ADDR_W      = $clog2(CELL_COUNT);
  localparam int CNT_W       = $clog2(CELL_COUNT + 1);
  localparam int COL_W       = 7;
  localparam int ROW_W       = 5;
  localparam int CELL_W      = 16;
  localparam int ATTR_W      = 8;
  localparam int CHAR_W      = 8;

  localparam logic [CELL_W-1:0] BLANK_WORD   = 16'h0720;
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h07;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_code_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_PUT,
    ST_CLEAR,
    ST_READ,
    ST_READ_WAIT,
    ST_SCROLL_COPY,
    ST_SCROLL_BLANK,
    ST_RESPOND
  } state_t;

  typedef struct packed {
    logic latch_req;
    logic put_wr;
    logic blank_wr;
    logic copy_rd;
    logic read_issue;
    logic read_capture;
    logic cnt_clear;
    logic cnt_inc;
    logic home;
    logic out_load;
  } tcw_ctrl_t;

  typedef struct packed {
    logic put_scroll;
    logic cnt_last;
    logic copy_done;
    logic out_free;
  } tcw_stat_t;

endpackage

// ----- rtl/core/tcw_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/core/tcw_datapath.sv -----
// Datapath of the text console writer: request latch, cursor, sweep counter,
// screen store, attribute register and output register.
// Depends on tcw_pkg and tcw_ram.
module tcw_datapath
  import tcw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  tcw_ctrl_t         ctrl,
  output tcw_stat_t         stat,
  input  logic [CHAR_W-1:0] req_code_in,
  input  logic [ROW_W-1:0]  req_row_in,
  input  logic [COL_W-1:0]  req_col_in,
  input  logic              cfg_wr_en,
  input  logic [ATTR_W-1:0] cfg_wr_data,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [31:0]       m_axis_tdata
);

  logic [CHAR_W-1:0] req_code;
  logic [ROW_W-1:0]  req_row;
  logic [COL_W-1:0]  req_col;
  logic [COL_W-1:0]  cur_col;
  logic [ROW_W-1:0]  cur_row;
  logic [ATTR_W-1:0] attr;
  logic [CNT_W-1:0]  cnt;
  logic              copy_pend;
  logic [ADDR_W-1:0] copy_waddr;
  logic [CELL_W-1:0] read_word;

  logic [ADDR_W-1:0] put_idx;
  logic [ADDR_W-1:0] read_idx;
  logic              read_ok;
  logic              is_newline;
  logic              col_end;
  logic              row_end;
  logic              row_inc;
  logic [COL_W-1:0]  col_next;
  logic [ROW_W-1:0]  row_next;

  logic              ram_wr_en;
  logic [ADDR_W-1:0] ram_wr_addr;
  logic [CELL_W-1:0] ram_wr_data;
  logic              ram_rd_en;
  logic [ADDR_W-1:0] ram_rd_addr;
  logic [CELL_W-1:0] ram_rd_data;

  assign put_idx  = ADDR_W'(cur_row) * ADDR_W'(SCREEN_COLS) + ADDR_W'(cur_col);
  assign read_idx = ADDR_W'(req_row) * ADDR_W'(SCREEN_COLS) + ADDR_W'(req_col);
  assign read_ok  = (req_row < ROW_W'(SCREEN_ROWS)) && (req_col < COL_W'(SCREEN_COLS));

  assign is_newline = (req_code == NEWLINE_CODE);
  assign col_end    = (cur_col == COL_W'(SCREEN_COLS - 1));
  assign row_end    = (cur_row == ROW_W'(SCREEN_ROWS - 1));
  assign row_inc    = is_newline || col_end;

  always_comb begin
    col_next = row_inc ? '0 : cur_col + COL_W'(1);
    row_next = cur_row;
    if (row_inc && !row_end) begin
      row_next = cur_row + ROW_W'(1);
    end
  end

  assign stat.put_scroll = row_inc && row_end;
  assign stat.cnt_last   = (cnt == CNT_W'(CELL_COUNT - 1));
  assign stat.copy_done  = (cnt == CNT_W'(COPY_COUNT));
  assign stat.out_free   = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = copy_waddr;
    ram_wr_data = ram_rd_data;
    if (ctrl.blank_wr) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = cnt[ADDR_W-1:0];
      ram_wr_data = BLANK_WORD;
    end else if (ctrl.put_wr) begin
      ram_wr_en   = !is_newline;
      ram_wr_addr = put_idx;
      ram_wr_data = {attr, req_code};
    end else if (copy_pend) begin
      ram_wr_en   = 1'b1;
    end
  end

  assign ram_rd_en   = ctrl.copy_rd || ctrl.read_issue;
  assign ram_rd_addr = ctrl.copy_rd ? (cnt[ADDR_W-1:0] + ADDR_W'(SCREEN_COLS)) : read_idx;

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_screen (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (ctrl.latch_req) begin
      req_code <= req_code_in;
      req_row  <= req_row_in;
      req_col  <= req_col_in;
    end
    copy_waddr <= cnt[ADDR_W-1:0];
    if (ctrl.latch_req) begin
      read_word <= '0;
    end else if (ctrl.read_capture && read_ok) begin
      read_word <= ram_rd_data;
    end
    if (ctrl.out_load) begin
      m_axis_tdata <= {4'b0, cur_row, cur_col, read_word};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col       <= '0;
      cur_row       <= '0;
      attr          <= ATTR_RESET;
      cnt           <= '0;
      copy_pend     <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        attr <= cfg_wr_data;
      end
      if (ctrl.home) begin
        cur_col <= '0;
        cur_row <= '0;
      end else if (ctrl.put_wr) begin
        cur_col <= col_next;
        cur_row <= row_next;
      end
      if (ctrl.cnt_clear || ctrl.latch_req) begin
        cnt <= '0;
      end else if (ctrl.cnt_inc) begin
        cnt <= cnt + CNT_W'(1);
      end
      copy_pend <= ctrl.copy_rd;
      if (ctrl.out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    ctrl.out_load |=> m_axis_tvalid)
    else $error("output register not valid after load");

  a_no_write_clash: assert property (@(posedge clk) disable iff (rst)
    !(copy_pend && (ctrl.put_wr || ctrl.blank_wr)))
    else $error("scroll copy write collides with another store write");

  a_put_cursor_range: assert property (@(posedge clk) disable iff (rst)
    ctrl.put_wr |=> (cur_col < COL_W'(SCREEN_COLS)) && (cur_row < ROW_W'(SCREEN_ROWS)))
    else $error("cursor left the screen after a put");

endmodule

// ----- rtl/core/tcw_ctrl.sv -----
// Controller state machine of the text console writer: sequences put, clear,
// read, scroll and the store clearing pass after reset.
// Depends on tcw_pkg.
module tcw_ctrl
  import tcw_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [1:0] s_axis_tuser,
  input  tcw_stat_t  stat,
  output tcw_ctrl_t  ctrl
);

  state_t state;
  state_t state_next;
  logic   accept;

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctrl       = '0;
    case (state)
      ST_INIT: begin
        ctrl.blank_wr = 1'b1;
        ctrl.cnt_inc  = 1'b1;
        if (stat.cnt_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          ctrl.latch_req = 1'b1;
          case (cmd_code_t'(s_axis_tuser))
            CMD_PUT:   state_next = ST_PUT;
            CMD_CLEAR: state_next = ST_CLEAR;
            CMD_READ:  state_next = ST_READ;
            default:   state_next = ST_RESPOND;
          endcase
        end
      end
      ST_PUT: begin
        ctrl.put_wr    = 1'b1;
        ctrl.cnt_clear = 1'b1;
        state_next     = stat.put_scroll ? ST_SCROLL_COPY : ST_RESPOND;
      end
      ST_SCROLL_COPY: begin
        if (stat.copy_done) begin
          state_next = ST_SCROLL_BLANK;
        end else begin
          ctrl.copy_rd = 1'b1;
          ctrl.cnt_inc = 1'b1;
        end
      end
      ST_SCROLL_BLANK: begin
        ctrl.blank_wr = 1'b1;
        ctrl.cnt_inc  = 1'b1;
        if (stat.cnt_last) begin
          state_next = ST_RESPOND;
        end
      end
      ST_CLEAR: begin
        ctrl.blank_wr = 1'b1;
        ctrl.cnt_inc  = 1'b1;
        ctrl.home     = 1'b1;
        if (stat.cnt_last) begin
          state_next = ST_RESPOND;
        end
      end
      ST_READ: begin
        ctrl.read_issue = 1'b1;
        state_next      = ST_READ_WAIT;
      end
      ST_READ_WAIT: begin
        ctrl.read_capture = 1'b1;
        state_next        = ST_RESPOND;
      end
      ST_RESPOND: begin
        if (stat.out_free) begin
          ctrl.out_load = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != ST_IDLE)
    else $error("controller stayed idle after a transfer");

  a_respond_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RESPOND && stat.out_free) |=> state == ST_IDLE)
    else $error("result loaded but controller did not return to idle");

  a_scroll_from_put: assert property (@(posedge clk) disable iff (rst)
    $rose(state == ST_SCROLL_COPY) |-> $past(state) == ST_PUT)
    else $error("scroll entered from a state other than put");

endmodule

// ----- rtl/core/text_console_writer.sv -----
// Text console writer top level: 80 x 25 screen store of attribute/character cells with cursor.
// One item at a time; a waiting result does not block the next transfer.
// Clear walks all 2000 cells. A put that scrolls adds a copy pass over 1920 cells
// and a blanking pass over 80 cells, through the screen store's single ports.
// rst (synchronous) starts a clearing pass over all 2000 cells; no transfer until
// done. Depends on tcw_pkg, tcw_ctrl, tcw_datapath and tcw_ram.
module text_console_writer
  import tcw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // char_code[7:0], read_row[12:8], read_col[19:13]
  input  logic [1:0]  s_axis_tuser,  // cmd[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // cell_word[15:0], cursor_col[22:16], cursor_row[27:23]
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);

  tcw_ctrl_t ctrl;
  tcw_stat_t stat;

  tcw_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .stat          (stat),
    .ctrl          (ctrl)
  );

  tcw_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .stat          (stat),
    .req_code_in   (s_axis_tdata[7:0]),
    .req_row_in    (s_axis_tdata[12:8]),
    .req_col_in    (s_axis_tdata[19:13]),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// ----- tb/tb_top.sv -----
// Testbench for text_console_writer: streams console commands in, keeps a shadow
// screen and cursor to predict every reply, and checks the reply stream.
// Depends on tcw_pkg and the text_console_writer RTL.
module tb_top
  import tcw_pkg::*;
();

  localparam int QUIET_LIMIT      = 40000;
  localparam int TAIL_CYCLES      = 50;
  localparam int RANDOM_PER_PHASE = 325;

  class console_shadow;
    logic [CELL_W-1:0] cells [CELL_COUNT];
    int unsigned       col;
    int unsigned       row;
    logic [ATTR_W-1:0] attr;
    logic [31:0]       pending_replies [$];
    int unsigned       mismatches;

    function new();
      blank_cells();
      col        = 0;
      row        = 0;
      attr       = ATTR_RESET;
      mismatches = 0;
    endfunction

    function void blank_cells();
      foreach (cells[i]) cells[i] = BLANK_WORD;
    endfunction

    function void scroll_one_row();
      for (int i = 0; i < COPY_COUNT; i++) cells[i] = cells[i + SCREEN_COLS];
      for (int i = COPY_COUNT; i < CELL_COUNT; i++) cells[i] = BLANK_WORD;
      row = SCREEN_ROWS - 1;
    endfunction

    function void put_code(logic [CHAR_W-1:0] code);
      int unsigned idx;
      if (code == NEWLINE_CODE) begin
        col = 0;
        row++;
      end else begin
        idx = row * SCREEN_COLS + col;
        if (idx < CELL_COUNT) cells[idx] = {attr, code};
        col++;
      end
      if (col >= SCREEN_COLS) begin
        col = 0;
        row++;
      end
      if (row >= SCREEN_ROWS) scroll_one_row();
    endfunction

    function void apply_command(cmd_code_t c, logic [CHAR_W-1:0] code,
                                logic [ROW_W-1:0] rr, logic [COL_W-1:0] rc);
      logic [CELL_W-1:0] read_word;
      read_word = '0;
      case (c)
        CMD_PUT: begin
          put_code(code);
        end
        CMD_CLEAR: begin
          blank_cells();
          col = 0;
          row = 0;
        end
        CMD_READ: begin
          if (rr < SCREEN_ROWS && rc < SCREEN_COLS) read_word = cells[rr * SCREEN_COLS + rc];
        end
        default: begin
        end
      endcase
      pending_replies.push_back({4'b0, ROW_W'(row), COL_W'(col), read_word});
    endfunction

    function void compare_reply(logic [31:0] got);
      logic [31:0] want;
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("tb_top: reply %h with nothing pending", got);
      end else begin
        want = pending_replies.pop_front();
        if (got[15:0] !== want[15:0] || got[22:16] !== want[22:16] ||
            got[27:23] !== want[27:23]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("tb_top: reply mismatch: cell %h/%h col %0d/%0d row %0d/%0d (exp/got)",
                     want[15:0], got[15:0], want[22:16], got[22:16],
                     want[27:23], got[27:23]);
        end
      end
    endfunction
  endclass

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        cfg_wr_en     = 1'b0;
  logic [7:0]  cfg_wr_data   = '0;

  int unsigned   gap_pct   = 0;
  int unsigned   stall_pct = 0;
  console_shadow shadow    = new();

  text_console_writer u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) shadow.compare_reply(m_axis_tdata);
  end

  task automatic send_item(cmd_code_t c, logic [CHAR_W-1:0] code,
                           logic [ROW_W-1:0] rr, logic [COL_W-1:0] rc);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, rc, rr, code};
    s_axis_tuser  <= c;
    do @(posedge clk); while (!s_axis_tready);
    shadow.apply_command(c, code, rr, rc);
  endtask

  task automatic send_random_item();
    int unsigned     pick;
    cmd_code_t       c;
    logic [CHAR_W-1:0] code;
    logic [ROW_W-1:0]  rr;
    logic [COL_W-1:0]  rc;
    pick = $urandom_range(999);
    code = CHAR_W'($urandom);
    rr   = ROW_W'($urandom);
    rc   = COL_W'($urandom);
    if (pick < 850) begin
      c = CMD_PUT;
      if ($urandom_range(99) < 12) code = NEWLINE_CODE;
    end else if (pick < 975) begin
      c = CMD_READ;
      if ($urandom_range(9) != 0) begin
        rr = ($urandom_range(1) != 0) ? ROW_W'(shadow.row) : ROW_W'($urandom_range(24));
        rc = COL_W'($urandom_range(SCREEN_COLS - 1));
      end
    end else if (pick < 980) begin
      c = CMD_CLEAR;
    end else begin
      c = CMD_NONE;
    end
    send_item(c, code, rr, rc);
  endtask

  // drop valid and hold until every reply is back
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (shadow.pending_replies.size() != 0);
  endtask

  task automatic write_attribute(logic [ATTR_W-1:0] value);
    cfg_wr_data <= value;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    shadow.attr = value;
  endtask

  task automatic run_phase(int unsigned gp, int unsigned sp, logic [ATTR_W-1:0] value);
    settle();
    write_attribute(value);
    gap_pct   = gp;
    stall_pct = sp;
    for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
      if (k == RANDOM_PER_PHASE / 2) settle();
      send_random_item();
    end
  endtask

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset contents, corners, out-of-range reads, puts, a newline and a clear under the reset attribute
    send_item(CMD_READ,  8'h00, 5'd0,  7'd0);
    send_item(CMD_READ,  8'hFF, 5'd24, 7'd79);
    send_item(CMD_READ,  8'h5A, 5'd31, 7'd127);
    send_item(CMD_READ,  8'h00, 5'd25, 7'd0);
    send_item(CMD_READ,  8'h00, 5'd0,  7'd80);
    send_item(CMD_NONE,  8'hFF, 5'd31, 7'd127);
    send_item(CMD_PUT,   8'h00, 5'd31, 7'd127);
    send_item(CMD_PUT,   8'hFF, 5'd0,  7'd0);
    send_item(CMD_PUT,   8'h80, 5'd0,  7'd0);
    send_item(CMD_PUT,   NEWLINE_CODE, 5'd0, 7'd0);
    send_item(CMD_PUT,   8'h41, 5'd0,  7'd0);
    send_item(CMD_READ,  8'h00, 5'd0,  7'd0);
    send_item(CMD_READ,  8'h00, 5'd0,  7'd1);
    send_item(CMD_READ,  8'h00, 5'd0,  7'd2);
    send_item(CMD_READ,  8'h00, 5'd1,  7'd0);
    send_item(CMD_READ,  8'h00, 5'd1,  7'd1);
    send_item(CMD_CLEAR, 8'hFF, 5'd31, 7'd127);
    send_item(CMD_READ,  8'h00, 5'd0,  7'd1);
    send_item(CMD_READ,  8'h00, 5'd1,  7'd0);
    send_item(CMD_NONE,  8'h00, 5'd0,  7'd0);

    run_phase(0,  0,  8'h00);
    run_phase(47, 0,  8'hFF);
    run_phase(0,  47, ATTR_W'($urandom_range(1, 254)));
    run_phase(26, 26, ATTR_W'($urandom_range(1, 254)));

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (shadow.mismatches == 0 && shadow.pending_replies.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/tcw_pkg.sv
rtl/core/tcw_ram.sv
rtl/core/tcw_datapath.sv
rtl/core/tcw_ctrl.sv
rtl/core/text_console_writer.sv
tb/tb_top.sv
